>>> hw/rtl/tcb_spline_tangent_stream_defines.svh
// Assertion macros for the spline tangent stream block.
`ifndef TCB_SPLINE_TANGENT_STREAM_DEFINES_SVH
`define TCB_SPLINE_TANGENT_STREAM_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TCB_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tcb check failed");
// Assert that a condition implies a consequence in the next cycle.
`define TCB_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tcb check failed");
`endif

>>> hw/rtl/tcb_pkg.sv
// Shared types, constants and weight helpers for the spline tangent stream.
package tcb_pkg;
  localparam int COORD_BITS  = 24;
  localparam int WEIGHT_BITS = 16;
  localparam int INDEX_BITS  = 16;
  localparam int FRAC        = WEIGHT_BITS - 2;
  localparam int FB          = WEIGHT_BITS + 1;  // one +/- x factor
  localparam int WW          = WEIGHT_BITS + 4;  // formed weight, up to 27 times one
  localparam int DB          = COORD_BITS + 1;   // coordinate difference
  localparam int PB          = WW + DB;          // weight times difference
  localparam int AB          = PB + 1;           // accumulator

  typedef enum logic [3:0] {
    ST_IDLE, ST_W1, ST_W2, ST_M0, ST_M1, ST_M2, ST_M3, ST_SEND1, ST_LW1, ST_LW2,
    ST_LM, ST_SEND2
  } state_t;

  // Factor selector for the shared weight multiplier.
  typedef enum logic [1:0] {
    WS_IN_N, WS_IN_P, WS_OUT_N, WS_OUT_P
  } wsel_t;

  typedef struct packed {
    logic       load_first;   // capture first point
    logic       shift_point;  // advance point window
    logic       calc_w_a;     // weight step one for selected weight
    logic       calc_w_b;     // weight step two
    wsel_t      wsel;
    logic       use_new;      // weights from the arriving point (last point)
    logic       mac_clear;
    logic       mac_dp;       // multiply against d_prev instead of d_next
    logic       mac_half;     // middle point shift
    logic       mac_to_out;   // accumulate into outgoing set
    logic       mac_en;
    logic       load_out1;    // result of held point
    logic       load_out2;    // result of last point
    logic       load_single;  // lone point curve
    logic       clear_all;
  } cmd_t;

  typedef struct packed {
    logic [1:0] held_count;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [AB-1:0] v);
    logic signed [AB-1:0] mx;
    logic signed [AB-1:0] mn;
    mx = AB'(32'sh7fffffff);
    mn = -AB'(33'sh80000000);
    if (v > mx) sat32 = 32'sh7fffffff;
    else if (v < mn) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

>>> hw/rtl/tcb_ctrl.sv
// Sequencer for the spline tangent stream: steps the shared multipliers.
module tcb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           last_in,
  input  logic           out_ready,
  input  tcb_pkg::stat_t stat,
  output logic           in_ready,
  output logic           out_valid,
  output tcb_pkg::cmd_t  cmd
);
  tcb_pkg::state_t state, state_next;
  logic last_seen, last_seen_next;
  logic [1:0] lane, lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcb_pkg::ST_IDLE;
      last_seen <= 1'b0;
      lane <= 2'd0;
    end else begin
      state <= state_next;
      last_seen <= last_seen_next;
      lane <= lane_next;
    end
  end

  always_comb begin
    state_next = state;
    last_seen_next = last_seen;
    lane_next = lane;
    cmd = '0;
    cmd.wsel = tcb_pkg::WS_IN_N;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      tcb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          last_seen_next = last_in;
          if (stat.held_count == 2'd0) begin
            if (last_in) begin
              cmd.load_single = 1'b1;
              state_next = tcb_pkg::ST_SEND2;
            end else begin
              cmd.load_first = 1'b1;
            end
          end else begin
            lane_next = 2'd0;
            state_next = tcb_pkg::ST_W1;
          end
        end
      end
      tcb_pkg::ST_W1: begin
        cmd.calc_w_a = 1'b1;
        cmd.wsel = tcb_pkg::wsel_t'(lane);
        state_next = tcb_pkg::ST_W2;
      end
      tcb_pkg::ST_W2: begin
        cmd.calc_w_b = 1'b1;
        cmd.wsel = tcb_pkg::wsel_t'(lane);
        state_next = tcb_pkg::ST_M0;
      end
      tcb_pkg::ST_M0: begin
        // Multiply all three axes at once; the first product of each tangent starts its sum.
        cmd.mac_en = 1'b1;
        cmd.mac_clear = !lane[0];
        cmd.mac_half = (stat.held_count == 2'd2);
        cmd.mac_dp = lane[0];
        cmd.mac_to_out = lane[1];
        state_next = tcb_pkg::ST_M1;
      end
      tcb_pkg::ST_M1: begin
        if (stat.held_count == 2'd1 || lane == 2'd3) begin
          state_next = tcb_pkg::ST_SEND1;
        end else begin
          lane_next = lane + 2'd1;
          state_next = tcb_pkg::ST_W1;
        end
      end
      tcb_pkg::ST_SEND1: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_seen) begin
            state_next = tcb_pkg::ST_LW1;
          end else begin
            cmd.shift_point = 1'b1;
            state_next = tcb_pkg::ST_IDLE;
          end
        end
      end
      tcb_pkg::ST_LW1: begin
        cmd.calc_w_a = 1'b1;
        cmd.use_new = 1'b1;
        state_next = tcb_pkg::ST_LW2;
      end
      tcb_pkg::ST_LW2: begin
        cmd.calc_w_b = 1'b1;
        cmd.use_new = 1'b1;
        state_next = tcb_pkg::ST_LM;
      end
      tcb_pkg::ST_LM: begin
        cmd.mac_en = 1'b1;
        cmd.mac_clear = 1'b1;
        cmd.load_out2 = 1'b1;
        state_next = tcb_pkg::ST_M2;
      end
      tcb_pkg::ST_M2: begin
        state_next = tcb_pkg::ST_SEND2;
      end
      tcb_pkg::ST_SEND2: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear_all = 1'b1;
          state_next = tcb_pkg::ST_IDLE;
        end
      end
      default: state_next = tcb_pkg::ST_IDLE;
    endcase
    cmd.load_out1 = (state == tcb_pkg::ST_M1) &&
                    (stat.held_count == 2'd1 || lane == 2'd3);
  end
endmodule

>>> hw/rtl/tcb_datapath.sv
// Point window, shared weight multiplier and three-axis tangent products.
module tcb_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tcb_pkg::cmd_t                         cmd,
  input  logic signed [tcb_pkg::COORD_BITS-1:0] new_x,
  input  logic signed [tcb_pkg::COORD_BITS-1:0] new_y,
  input  logic signed [tcb_pkg::COORD_BITS-1:0] new_z,
  input  logic signed [tcb_pkg::WEIGHT_BITS-1:0] new_t,
  input  logic signed [tcb_pkg::WEIGHT_BITS-1:0] new_c,
  input  logic signed [tcb_pkg::WEIGHT_BITS-1:0] new_b,
  input  logic                                  load_new,
  output tcb_pkg::stat_t                        stat,
  output logic [15:0]                           point_index,
  output logic                                  has_incoming,
  output logic                                  has_outgoing,
  output logic signed [31:0]                    in_x,
  output logic signed [31:0]                    in_y,
  output logic signed [31:0]                    in_z,
  output logic signed [31:0]                    out_x,
  output logic signed [31:0]                    out_y,
  output logic signed [31:0]                    out_z,
  output logic                                  curve_end
);
  localparam int CB = tcb_pkg::COORD_BITS;
  localparam int WB = tcb_pkg::WEIGHT_BITS;
  localparam int FB = tcb_pkg::FB;
  localparam int WW = tcb_pkg::WW;
  localparam int DB = tcb_pkg::DB;
  localparam int PB = tcb_pkg::PB;
  localparam int AB = tcb_pkg::AB;
  localparam int FR = tcb_pkg::FRAC;

  logic signed [CB-1:0] prv [3];
  logic signed [CB-1:0] cur [3];
  logic signed [CB-1:0] nxt [3];
  logic signed [WB-1:0] ht, hc, hb, nt, nc, nb;
  logic [1:0] held_count;
  logic [tcb_pkg::INDEX_BITS-1:0] index_counter;
  logic signed [2*FB-1:0] prod_a;
  logic signed [WW+FB-1:0] prod_b;
  logic signed [WW-1:0] w1, wt;
  logic signed [FB-1:0] f1, f2, f3;
  logic signed [FB-1:0] omt, omc, opc, omb, opb;
  logic signed [AB-1:0] acc_in [3];
  logic signed [AB-1:0] acc_out [3];
  logic signed [AB-1:0] term [3];
  logic signed [AB-1:0] sum [3];
  logic signed [FB-1:0] one;

  assign one = FB'(1) <<< FR;
  assign stat.held_count = held_count;

  always_comb begin
    logic signed [WB-1:0] t, c, b;
    t = cmd.use_new ? nt : ht;
    c = cmd.use_new ? nc : hc;
    b = cmd.use_new ? nb : hb;
    omt = one - FB'(t);
    omc = one - FB'(c);
    opc = one + FB'(c);
    omb = one - FB'(b);
    opb = one + FB'(b);
    f1 = omt;
    if (cmd.use_new) begin
      f2 = omc; f3 = opb;
    end else begin
      unique case (cmd.wsel)
        tcb_pkg::WS_IN_N:  begin f2 = omc; f3 = omb; end
        tcb_pkg::WS_IN_P:  begin f2 = opc; f3 = opb; end
        tcb_pkg::WS_OUT_N: begin f2 = opc; f3 = omb; end
        default:           begin f2 = omc; f3 = opb; end
      endcase
    end
    // Held point alone uses the in-from-next weight for its outgoing tangent.
  end

  // Weight steps at full width; the formed weight reaches 27 times one.
  assign prod_a = (2*FB)'(f1) * (2*FB)'(f2);
  assign prod_b = (WW+FB)'(w1) * (WW+FB)'(f3);

  // Products: weight times difference, floored by the point's shift.
  always_comb begin
    logic signed [DB-1:0] d;
    logic signed [PB-1:0] p;
    for (int k = 0; k < 3; k++) begin
      if (cmd.mac_dp) d = DB'(cur[k]) - DB'(prv[k]);
      else d = DB'(nxt[k]) - DB'(cur[k]);
      p = PB'(wt) * PB'(d);
      if (cmd.mac_half) term[k] = AB'(p >>> (FR + 1));
      else term[k] = AB'(p >>> FR);
      if (cmd.mac_to_out) sum[k] = (cmd.mac_clear ? '0 : acc_out[k]) + term[k];
      else sum[k] = (cmd.mac_clear ? '0 : acc_in[k]) + term[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      index_counter <= '0;
      for (int k = 0; k < 3; k++) begin
        prv[k] <= '0; cur[k] <= '0;
      end
      ht <= '0; hc <= '0; hb <= '0;
    end else begin
      if (cmd.load_first) begin
        held_count <= 2'd1;
        index_counter <= index_counter + 1'b1;
        cur[0] <= new_x; cur[1] <= new_y; cur[2] <= new_z;
        ht <= new_t; hc <= new_c; hb <= new_b;
      end else if (cmd.shift_point) begin
        held_count <= 2'd2;
        index_counter <= index_counter + 1'b1;
        for (int k = 0; k < 3; k++) begin
          prv[k] <= cur[k]; cur[k] <= nxt[k];
        end
        ht <= nt; hc <= nc; hb <= nb;
      end else if (cmd.clear_all) begin
        held_count <= 2'd0;
        index_counter <= '0;
        for (int k = 0; k < 3; k++) begin
          prv[k] <= '0; cur[k] <= '0;
        end
        ht <= '0; hc <= '0; hb <= '0;
      end
    end
  end

  // Arriving point and shared arithmetic registers.
  always_ff @(posedge clk) begin
    if (load_new) begin
      nxt[0] <= new_x; nxt[1] <= new_y; nxt[2] <= new_z;
      nt <= new_t; nc <= new_c; nb <= new_b;
    end
    if (cmd.calc_w_a) w1 <= WW'(prod_a >>> FR);
    if (cmd.calc_w_b) wt <= WW'(prod_b >>> FR);
    if (cmd.mac_en) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd.mac_to_out) acc_out[k] <= sum[k];
        else acc_in[k] <= sum[k];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out1) begin
      point_index <= 16'(index_counter - 1'b1);
      has_incoming <= (held_count == 2'd2);
      has_outgoing <= 1'b1;
      curve_end <= 1'b0;
      if (held_count == 2'd2) begin
        in_x <= tcb_pkg::sat32(acc_in[0]);
        in_y <= tcb_pkg::sat32(acc_in[1]);
        in_z <= tcb_pkg::sat32(acc_in[2]);
        out_x <= tcb_pkg::sat32(acc_out[0]);
        out_y <= tcb_pkg::sat32(acc_out[1]);
        out_z <= tcb_pkg::sat32(acc_out[2]);
      end else begin
        in_x <= '0; in_y <= '0; in_z <= '0;
        out_x <= tcb_pkg::sat32(acc_in[0]);
        out_y <= tcb_pkg::sat32(acc_in[1]);
        out_z <= tcb_pkg::sat32(acc_in[2]);
      end
    end else if (cmd.load_out2) begin
      point_index <= 16'(index_counter);
      has_incoming <= 1'b1;
      has_outgoing <= 1'b0;
      curve_end <= 1'b1;
      in_x <= tcb_pkg::sat32(sum[0]);
      in_y <= tcb_pkg::sat32(sum[1]);
      in_z <= tcb_pkg::sat32(sum[2]);
      out_x <= '0; out_y <= '0; out_z <= '0;
    end else if (cmd.load_single) begin
      point_index <= 16'(index_counter);
      has_incoming <= 1'b0;
      has_outgoing <= 1'b0;
      curve_end <= 1'b1;
      in_x <= '0; in_y <= '0; in_z <= '0;
      out_x <= '0; out_y <= '0; out_z <= '0;
    end
  end
endmodule

>>> hw/rtl/tcb_spline_tangent_stream.sv
// Top level of the tension-continuity-bias spline tangent stream.
// A held point's result is offered once the next point is taken and its weights are formed:
// one weight (W1, W2, M0, M1) for the curve's first point, four weights for later ones.
// A new point is taken only after the result is handed over, as the one shared
// weight multiplier forms the weights in turn; a curve's first point is just held.
// The last point adds a second result; a lone point's result is offered on the next cycle.
// Reset (synchronous, rst high) empties the point window and clears the index.
`include "tcb_spline_tangent_stream_defines.svh"
module tcb_spline_tangent_stream (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  point_x,
  input  logic signed [23:0]  point_y,
  input  logic signed [23:0]  point_z,
  input  logic signed [15:0]  tension,
  input  logic signed [15:0]  continuity,
  input  logic signed [15:0]  bias,
  input  logic                last_point,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         point_index,
  output logic                has_incoming,
  output logic                has_outgoing,
  output logic signed [31:0]  in_x,
  output logic signed [31:0]  in_y,
  output logic signed [31:0]  in_z,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                curve_end
);
  tcb_pkg::cmd_t  cmd;
  tcb_pkg::stat_t stat;
  logic in_fire;

  // Take an item only when the sequencer is idle.
  assign in_fire = in_valid && in_ready;

  tcb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .last_in(last_point),
    .out_ready(out_ready), .stat(stat), .in_ready(in_ready),
    .out_valid(out_valid), .cmd(cmd)
  );

  tcb_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .new_x(point_x), .new_y(point_y), .new_z(point_z),
    .new_t(tension), .new_c(continuity), .new_b(bias),
    .load_new(in_fire), .stat(stat),
    .point_index(point_index), .has_incoming(has_incoming),
    .has_outgoing(has_outgoing), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .curve_end(curve_end)
  );

  // Never take an item while a result is on offer.
  `TCB_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  // After the curve's end is handed over, the window is empty.
  `TCB_ASSERT_NEXT(a_end_clears, clk, rst, out_valid && out_ready && curve_end,
    stat.held_count == 2'd0)
  // A lone-tangent result never flags both tangents at the curve end.
  `TCB_ASSERT_IMP(a_end_flags, clk, rst, out_valid && curve_end,
    !(has_incoming && has_outgoing))
endmodule
